[design/dsuf_pkg.sv]
// Shared types and constants for the disjoint-set union-find engine.
// No dependencies; every other file of the block but dsuf_ram refers to this package.
package dsuf_pkg;

   localparam int MAX_ELEMENTS_DEFAULT = 1024;

   localparam int KIND_W  = 2;
   localparam int INDEX_W = 10;
   localparam int COUNT_W = 11;
   localparam int RANK_W  = 4;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;
   localparam logic [RANK_W-1:0]  RANK_RESET  = 4'd1;
   localparam logic [RANK_W-1:0]  RANK_MAX    = 4'd15;

   // Operation codes; the unused code behaves as find
   localparam logic [KIND_W-1:0] KIND_FIND  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_UNITE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SAME  = 2'd2;

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_WALK  = 7'b0000100,
      S_COMP  = 7'b0001000,
      S_LINK  = 7'b0010000,
      S_BUMP  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   typedef enum logic [1:0] {
      RD_REQ_A  = 2'd0,
      RD_REQ_B  = 2'd1,
      RD_PARENT = 2'd2,
      RD_START  = 2'd3
   } rd_sel_type;

   typedef enum logic [2:0] {
      WR_NONE  = 3'd0,
      WR_COMP  = 3'd1,
      WR_LINK  = 3'd2,
      WR_BUMP  = 3'd3,
      WR_CLEAR = 3'd4
   } wr_sel_type;

   typedef struct packed {
      logic       capture;
      logic       top_load;
      logic       cur_load;
      logic       save_root;
      logic       second;
      logic       clr_start;
      logic       clr_step;
      logic       out_load;
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
   } cmd_type;

   typedef struct packed {
      logic req_err;
      logic parent_is_top;
      logic start_is_top;
      logic two_op;
      logic is_unite;
      logic roots_equal;
      logic need_bump;
      logic clr_last;
   } sts_type;

endpackage

[design/dsuf_req_if.sv]
// Request channel of the union-find engine: valid/ready plus one request item.
// Depends on dsuf_pkg for field widths.
interface dsuf_req_if;
   logic                           valid;
   logic                           ready;
   logic [dsuf_pkg::KIND_W-1:0]    kind;
   logic [dsuf_pkg::INDEX_W-1:0]   first_element;
   logic [dsuf_pkg::INDEX_W-1:0]   second_element;

   modport source (output valid, kind, first_element, second_element, input ready);
   modport sink   (input valid, kind, first_element, second_element, output ready);
endinterface

[design/dsuf_rsp_if.sv]
// Response channel of the union-find engine: valid/ready plus one result item.
// Depends on dsuf_pkg for field widths.
interface dsuf_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [dsuf_pkg::INDEX_W-1:0]   root;
   logic                           flag;
   logic                           error;

   modport source (output valid, root, flag, error, input ready);
   modport sink   (input valid, root, flag, error, output ready);
endinterface

[design/dsuf_ram.sv]
// Generic single-write, single-read RAM with registered read data (read-first).
// No dependencies.
module dsuf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/dsuf_ctrl.sv]
// Sequencer of the union-find engine: walk, compress, link and clearing pass.
// Depends on dsuf_pkg; drives the datapath through cmd_type, reads sts_type.
module dsuf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              csr_we,
   input  dsuf_pkg::sts_type sts,
   output dsuf_pkg::cmd_type cmd
);

   dsuf_pkg::state_type state_ff, state_in;
   logic                second_ff, second_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;
   logic                go_b;
   dsuf_pkg::state_type after_find;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign go_b       = !second_ff && sts.two_op;
   assign after_find = go_b ? dsuf_pkg::S_WALK :
                       (sts.is_unite ? dsuf_pkg::S_LINK : dsuf_pkg::S_DONE);

   assign req_ready = (state_ff == dsuf_pkg::S_IDLE) && !csr_we;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      second_in     = second_ff;
      cmd           = '0;
      cmd.rd_sel    = dsuf_pkg::RD_PARENT;
      cmd.wr_sel    = dsuf_pkg::WR_NONE;
      cmd.second    = second_ff;

      case (state_ff)
         dsuf_pkg::S_CLEAR: begin
            cmd.wr_sel   = dsuf_pkg::WR_CLEAR;
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = dsuf_pkg::S_IDLE;
            end
         end
         dsuf_pkg::S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.capture = 1'b1;
               second_in   = 1'b0;
               if (sts.req_err) begin
                  state_in = dsuf_pkg::S_DONE;
               end else begin
                  cmd.rd_sel   = dsuf_pkg::RD_REQ_A;
                  cmd.top_load = 1'b1;
                  state_in     = dsuf_pkg::S_WALK;
               end
            end
         end
         dsuf_pkg::S_WALK: begin
            if (sts.parent_is_top) begin
               cmd.save_root = 1'b1;
               if (sts.start_is_top) begin
                  state_in = after_find;
                  if (go_b) begin
                     cmd.rd_sel   = dsuf_pkg::RD_REQ_B;
                     cmd.top_load = 1'b1;
                     second_in    = 1'b1;
                  end
               end else begin
                  cmd.rd_sel   = dsuf_pkg::RD_START;
                  cmd.cur_load = 1'b1;
                  state_in     = dsuf_pkg::S_COMP;
               end
            end else begin
               cmd.top_load = 1'b1;
            end
         end
         dsuf_pkg::S_COMP: begin
            cmd.wr_sel = dsuf_pkg::WR_COMP;
            if (sts.parent_is_top) begin
               state_in = after_find;
               if (go_b) begin
                  cmd.rd_sel   = dsuf_pkg::RD_REQ_B;
                  cmd.top_load = 1'b1;
                  second_in    = 1'b1;
               end
            end else begin
               cmd.cur_load = 1'b1;
            end
         end
         dsuf_pkg::S_LINK: begin
            if (sts.roots_equal) begin
               state_in = dsuf_pkg::S_DONE;
            end else begin
               cmd.wr_sel = dsuf_pkg::WR_LINK;
               state_in   = sts.need_bump ? dsuf_pkg::S_BUMP : dsuf_pkg::S_DONE;
            end
         end
         dsuf_pkg::S_BUMP: begin
            cmd.wr_sel = dsuf_pkg::WR_BUMP;
            state_in   = dsuf_pkg::S_DONE;
         end
         dsuf_pkg::S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = dsuf_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = dsuf_pkg::S_IDLE;
         end
      endcase

      // a size write restarts the clearing pass
      if (csr_we) begin
         cmd.clr_start = 1'b1;
         cmd.clr_step  = 1'b0;
         cmd.wr_sel    = dsuf_pkg::WR_NONE;
         state_in      = dsuf_pkg::S_CLEAR;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dsuf_pkg::S_CLEAR;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[design/dsuf_dp.sv]
// Datapath of the union-find engine: request registers, parent/rank store,
// walk and compress pointers, found roots and the result register.
// Depends on dsuf_pkg and dsuf_ram.
module dsuf_dp #(
   parameter int MAX_ELEMENTS = dsuf_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [dsuf_pkg::KIND_W-1:0]     req_kind,
   input  logic [dsuf_pkg::INDEX_W-1:0]    req_first_element,
   input  logic [dsuf_pkg::INDEX_W-1:0]    req_second_element,
   output logic [dsuf_pkg::INDEX_W-1:0]    rsp_root,
   output logic                            rsp_flag,
   output logic                            rsp_error,
   input  logic                            csr_we,
   input  logic [dsuf_pkg::COUNT_W-1:0]    csr_wdata,
   input  dsuf_pkg::cmd_type               cmd,
   output dsuf_pkg::sts_type               sts
);

   localparam int IW  = $clog2(MAX_ELEMENTS);
   localparam int RW  = dsuf_pkg::RANK_W;
   localparam int EW  = IW + RW;
   localparam int MBW = $clog2(MAX_ELEMENTS + 1);
   localparam int CW  = (dsuf_pkg::COUNT_W > MBW) ? dsuf_pkg::COUNT_W : MBW;
   localparam logic [CW-1:0] MAX_CW = CW'(MAX_ELEMENTS);
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ELEMENTS - 1);

   logic [dsuf_pkg::COUNT_W-1:0] count_ff;
   logic [dsuf_pkg::KIND_W-1:0]  kind_ff;
   logic [IW-1:0]                a_ff, b_ff;
   logic                         err_ff;
   logic [IW-1:0]                top_ff, cur_ff, clr_ff;
   logic [IW-1:0]                ra_ff, rb_ff;
   logic [RW-1:0]                rank_a_ff, rank_b_ff;
   logic [dsuf_pkg::INDEX_W-1:0] root_ff;
   logic                         flag_ff, error_ff;

   logic [CW-1:0] count_cw, live, a_cw, b_cw;
   logic          req_two;
   logic [IW-1:0] rd_addr, wr_addr, start_idx;
   logic [EW-1:0] rd_data, wr_data;
   logic          wr_en;
   logic [IW-1:0] rd_parent;
   logic [RW-1:0] rd_rank;
   logic          a_over;
   logic [IW-1:0] lo_idx, hi_idx;
   logic [RW-1:0] lo_rank, hi_rank;
   logic          is_unite, is_same;
   logic [IW-1:0] res_root;
   logic          res_flag;

   // range check against the live count (saturated at the store size)
   assign count_cw = CW'(count_ff);
   assign live     = (count_cw > MAX_CW) ? MAX_CW : count_cw;
   assign a_cw     = CW'(req_first_element);
   assign b_cw     = CW'(req_second_element);
   assign req_two  = (req_kind == dsuf_pkg::KIND_UNITE) || (req_kind == dsuf_pkg::KIND_SAME);

   assign rd_parent = rd_data[EW-1:RW];
   assign rd_rank   = rd_data[RW-1:0];
   assign start_idx = cmd.second ? b_ff : a_ff;

   assign is_unite = (kind_ff == dsuf_pkg::KIND_UNITE);
   assign is_same  = (kind_ff == dsuf_pkg::KIND_SAME);

   // ties go toward the second root
   assign a_over  = rank_a_ff > rank_b_ff;
   assign lo_idx  = a_over ? rb_ff : ra_ff;
   assign hi_idx  = a_over ? ra_ff : rb_ff;
   assign lo_rank = a_over ? rank_b_ff : rank_a_ff;
   assign hi_rank = a_over ? rank_a_ff : rank_b_ff;

   always_comb begin
      case (cmd.rd_sel)
         dsuf_pkg::RD_REQ_A:  rd_addr = IW'(req_first_element);
         dsuf_pkg::RD_REQ_B:  rd_addr = b_ff;
         dsuf_pkg::RD_PARENT: rd_addr = rd_parent;
         dsuf_pkg::RD_START:  rd_addr = start_idx;
         default:             rd_addr = rd_parent;
      endcase
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = cur_ff;
      wr_data = {top_ff, rd_rank};
      case (cmd.wr_sel)
         dsuf_pkg::WR_NONE: begin
            wr_en = 1'b0;
         end
         dsuf_pkg::WR_COMP: begin
            wr_addr = cur_ff;
            wr_data = {top_ff, rd_rank};
         end
         dsuf_pkg::WR_LINK: begin
            wr_addr = lo_idx;
            wr_data = {hi_idx, lo_rank};
         end
         dsuf_pkg::WR_BUMP: begin
            wr_addr = hi_idx;
            wr_data = {hi_idx, hi_rank + RW'(1)};
         end
         dsuf_pkg::WR_CLEAR: begin
            wr_addr = clr_ff;
            wr_data = {clr_ff, dsuf_pkg::RANK_RESET};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   dsuf_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_ELEMENTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      sts               = '0;
      sts.req_err       = (a_cw >= live) || (req_two && (b_cw >= live));
      sts.parent_is_top = (rd_parent == top_ff);
      sts.start_is_top  = (start_idx == top_ff);
      sts.two_op        = is_unite || is_same;
      sts.is_unite      = is_unite;
      sts.roots_equal   = (ra_ff == rb_ff);
      sts.need_bump     = (lo_rank == hi_rank) && (hi_rank != dsuf_pkg::RANK_MAX);
      sts.clr_last      = (clr_ff == LAST_IDX);
   end

   always_comb begin
      res_root = ra_ff;
      res_flag = 1'b0;
      if (is_unite) begin
         res_flag = (ra_ff != rb_ff);
         if (ra_ff != rb_ff) begin
            res_root = hi_idx;
         end
      end else if (is_same) begin
         res_flag = (ra_ff == rb_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= dsuf_pkg::COUNT_RESET;
         clr_ff   <= '0;
      end else begin
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
         if (cmd.clr_start) begin
            clr_ff <= '0;
         end else if (cmd.clr_step) begin
            clr_ff <= clr_ff + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         a_ff    <= IW'(req_first_element);
         b_ff    <= IW'(req_second_element);
         err_ff  <= sts.req_err;
      end
      if (cmd.top_load) begin
         top_ff <= rd_addr;
      end
      if (cmd.cur_load) begin
         cur_ff <= rd_addr;
      end
      if (cmd.save_root) begin
         if (cmd.second) begin
            rb_ff     <= top_ff;
            rank_b_ff <= rd_rank;
         end else begin
            ra_ff     <= top_ff;
            rank_a_ff <= rd_rank;
         end
      end
      if (cmd.out_load) begin
         root_ff  <= err_ff ? '0 : dsuf_pkg::INDEX_W'(res_root);
         flag_ff  <= err_ff ? 1'b0 : res_flag;
         error_ff <= err_ff;
      end
   end

   assign rsp_root  = root_ff;
   assign rsp_flag  = flag_ff;
   assign rsp_error = error_ff;

endmodule

[design/disjoint_set_union_find_top.sv]
// Union-find engine, path compression and union by rank. One item at a time.
// A rejected index goes straight to the result; a find walks the path to its
// root and then points each element on it at the root; same and unite also find
// the second root, and unite then links the two roots when they differ.
// Reset (synchronous, active high) and every csr write start a clearing pass
// over all MAX_ELEMENTS entries, during which no item is accepted.
module disjoint_set_union_find_top #(
   parameter int MAX_ELEMENTS = dsuf_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   dsuf_req_if.sink                     req_chan,
   dsuf_rsp_if.source                   rsp_chan,
   input  logic                         csr_we,
   input  logic [dsuf_pkg::COUNT_W-1:0] csr_wdata
);

   dsuf_pkg::cmd_type cmd;
   dsuf_pkg::sts_type sts;

   dsuf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .csr_we    (csr_we),
      .sts       (sts),
      .cmd       (cmd)
   );

   dsuf_dp #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_kind           (req_chan.kind),
      .req_first_element  (req_chan.first_element),
      .req_second_element (req_chan.second_element),
      .rsp_root           (rsp_chan.root),
      .rsp_flag           (rsp_chan.flag),
      .rsp_error          (rsp_chan.error),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .cmd                (cmd),
      .sts                (sts)
   );

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the disjoint-set union-find engine: directed table,
// then random phases. Holds its own forest model for prediction.
// Depends on dsuf_pkg, dsuf_req_if, dsuf_rsp_if and disjoint_set_union_find_top.
module tb_top;

   localparam logic [dsuf_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;
   localparam int STORE_DEPTH = dsuf_pkg::MAX_ELEMENTS_DEFAULT;
   localparam int PHASE_ITEMS = 150;

   typedef struct packed {
      logic [dsuf_pkg::INDEX_W-1:0] root;
      logic                         flag;
      logic                         error;
   } outcome_type;

   typedef struct packed {
      bit                           is_cfg;
      logic [dsuf_pkg::COUNT_W-1:0] cfg_value;
      logic [dsuf_pkg::KIND_W-1:0]  kind;
      logic [dsuf_pkg::INDEX_W-1:0] first;
      logic [dsuf_pkg::INDEX_W-1:0] second;
      bit                           typed;
      outcome_type                  want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [dsuf_pkg::COUNT_W-1:0] csr_wdata;

   dsuf_req_if req_if ();
   dsuf_rsp_if rsp_if ();

   disjoint_set_union_find_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // forest model
   logic [dsuf_pkg::INDEX_W-1:0] up_link [STORE_DEPTH];
   logic [dsuf_pkg::RANK_W-1:0]  height  [STORE_DEPTH];
   logic [dsuf_pkg::COUNT_W-1:0] count_reg;

   outcome_type    awaited_outcomes [$];
   script_row_type script [$];
   int             mismatch_count = 0;
   int             results_seen = 0;
   bit             calm = 1'b0;

   function automatic void make_singletons();
      for (int i = 0; i < STORE_DEPTH; i++) begin
         up_link[i] = i[dsuf_pkg::INDEX_W-1:0];
         height[i]  = dsuf_pkg::RANK_RESET;
      end
   endfunction

   // walk to the root, then point every visited entry straight at it
   function automatic logic [dsuf_pkg::INDEX_W-1:0] root_of(logic [dsuf_pkg::INDEX_W-1:0] e);
      logic [dsuf_pkg::INDEX_W-1:0] top;
      logic [dsuf_pkg::INDEX_W-1:0] cur;
      logic [dsuf_pkg::INDEX_W-1:0] nxt;
      int steps;
      top = e;
      steps = 0;
      while (up_link[top] != top && steps < STORE_DEPTH) begin
         top = up_link[top];
         steps++;
      end
      cur = e;
      steps = 0;
      while (cur != top && steps < STORE_DEPTH) begin
         nxt = up_link[cur];
         up_link[cur] = top;
         cur = nxt;
         steps++;
      end
      return top;
   endfunction

   function automatic outcome_type predict_outcome(logic [dsuf_pkg::KIND_W-1:0] kind,
                                                   logic [dsuf_pkg::INDEX_W-1:0] a,
                                                   logic [dsuf_pkg::INDEX_W-1:0] b);
      outcome_type o;
      int live;
      bit two;
      logic [dsuf_pkg::INDEX_W-1:0] ra;
      logic [dsuf_pkg::INDEX_W-1:0] rb;
      logic [dsuf_pkg::INDEX_W-1:0] lo;
      logic [dsuf_pkg::INDEX_W-1:0] hi;
      o = '0;
      live = (count_reg > STORE_DEPTH) ? STORE_DEPTH : int'(count_reg);
      two = (kind == dsuf_pkg::KIND_UNITE) || (kind == dsuf_pkg::KIND_SAME);
      if (a >= live || (two && b >= live)) begin
         o.error = 1'b1;
         return o;
      end
      if (kind == dsuf_pkg::KIND_UNITE) begin
         ra = root_of(a);
         rb = root_of(b);
         if (ra == rb) begin
            o.root = ra;
         end else begin
            lo = ra;
            hi = rb;
            if (height[ra] > height[rb]) begin
               lo = rb;
               hi = ra;
            end
            if (height[lo] == height[hi] && height[hi] < dsuf_pkg::RANK_MAX)
               height[hi] = height[hi] + 1'b1;
            up_link[lo] = hi;
            o.root = hi;
            o.flag = 1'b1;
         end
      end else if (kind == dsuf_pkg::KIND_SAME) begin
         ra = root_of(a);
         rb = root_of(b);
         o.root = ra;
         o.flag = (ra == rb);
      end else begin
         o.root = root_of(a);
      end
      return o;
   endfunction

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // biased toward a small window so sets grow and trees get deep
   function automatic logic [dsuf_pkg::INDEX_W-1:0] pick_index();
      int r;
      int live;
      int unsigned raw;
      live = (count_reg > STORE_DEPTH) ? STORE_DEPTH : int'(count_reg);
      r = $urandom_range(0, 99);
      if (r < 8 || live == 0)
         raw = $urandom_range(0, STORE_DEPTH - 1);
      else if (r < 60 && live > 32)
         raw = $urandom_range(0, 31);
      else
         raw = $urandom_range(0, live - 1);
      return raw[dsuf_pkg::INDEX_W-1:0];
   endfunction

   task automatic add_op(input logic [dsuf_pkg::KIND_W-1:0] k, input int a, input int b,
                         input bit typed, input int r, input bit f, input bit e);
      script_row_type row;
      row = '0;
      row.kind = k;
      row.first = a[dsuf_pkg::INDEX_W-1:0];
      row.second = b[dsuf_pkg::INDEX_W-1:0];
      row.typed = typed;
      row.want.root = r[dsuf_pkg::INDEX_W-1:0];
      row.want.flag = f;
      row.want.error = e;
      script.push_back(row);
   endtask

   task automatic add_cfg(input int v);
      script_row_type row;
      row = '0;
      row.is_cfg = 1'b1;
      row.cfg_value = v[dsuf_pkg::COUNT_W-1:0];
      script.push_back(row);
   endtask

   // only while the engine is idle; the write restarts every element as a singleton
   task automatic write_count(input logic [dsuf_pkg::COUNT_W-1:0] v);
      req_if.valid <= 1'b0;
      while (awaited_outcomes.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      count_reg = v;
      make_singletons();
   endtask

   task automatic send_item(input logic [dsuf_pkg::KIND_W-1:0] k,
                            input logic [dsuf_pkg::INDEX_W-1:0] a,
                            input logic [dsuf_pkg::INDEX_W-1:0] b,
                            output outcome_type predicted);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.kind <= k;
      req_if.first_element <= a;
      req_if.second_element <= b;
      do
         @(posedge clock);
      while (req_if.ready !== 1'b1);
      predicted = predict_outcome(k, a, b);
   endtask

   // result checker
   always @(posedge clock) begin : check_rsp
      outcome_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         results_seen++;
         if (awaited_outcomes.size() == 0) begin
            $error("result with nothing awaited: root %0d flag %0d error %0d",
                   rsp_if.root, rsp_if.flag, rsp_if.error);
            mismatch_count++;
         end else begin
            want = awaited_outcomes.pop_front();
            if (rsp_if.root !== want.root) begin
               $error("root: expected %0d, got %0d", want.root, rsp_if.root);
               mismatch_count++;
            end
            if (rsp_if.flag !== want.flag) begin
               $error("flag: expected %0d, got %0d", want.flag, rsp_if.flag);
               mismatch_count++;
            end
            if (rsp_if.error !== want.error) begin
               $error("error: expected %0d, got %0d", want.error, rsp_if.error);
               mismatch_count++;
            end
         end
      end
   end

   // result side: random back-pressure plus one long hold-off to fill the engine
   initial begin : drain
      int hold_left;
      bit long_done;
      hold_left = 0;
      long_done = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!long_done && results_seen >= 400) begin
            long_done = 1'b1;
            hold_left = 300;
         end else if (hold_left == 0 && !calm && $urandom_range(0, 99) < 20) begin
            hold_left = pick_gap();
         end
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      outcome_type predicted;
      script_row_type row;
      int plan [9];
      logic [dsuf_pkg::KIND_W-1:0] k;
      logic [dsuf_pkg::INDEX_W-1:0] ia;
      logic [dsuf_pkg::INDEX_W-1:0] ib;
      int unsigned raw;
      int r;

      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.kind = dsuf_pkg::KIND_FIND;
      req_if.first_element = '0;
      req_if.second_element = '0;
      count_reg = dsuf_pkg::COUNT_RESET;
      make_singletons();

      // state after reset: 1024 singletons
      add_op(dsuf_pkg::KIND_FIND,  0,    0,    1, 0,    0, 0);
      add_op(dsuf_pkg::KIND_FIND,  1023, 0,    1, 1023, 0, 0);
      add_op(dsuf_pkg::KIND_UNITE, 0,    1023, 1, 1023, 1, 0);  // equal ranks: second root wins
      add_op(dsuf_pkg::KIND_SAME,  0,    1023, 1, 1023, 1, 0);
      add_op(dsuf_pkg::KIND_SAME,  1,    2,    1, 1,    0, 0);
      add_op(KIND_SPARE,           0,    1023, 1, 1023, 0, 0);  // unused code acts as find
      add_op(dsuf_pkg::KIND_UNITE, 1,    2,    0, 0,    0, 0);
      add_op(dsuf_pkg::KIND_UNITE, 2,    0,    0, 0,    0, 0);
      add_op(dsuf_pkg::KIND_FIND,  1,    0,    0, 0,    0, 0);
      add_cfg(5);
      add_op(dsuf_pkg::KIND_FIND,  5,    0,    1, 0,    0, 1);
      add_op(dsuf_pkg::KIND_UNITE, 4,    5,    1, 0,    0, 1);
      add_op(dsuf_pkg::KIND_SAME,  5,    0,    1, 0,    0, 1);
      add_op(dsuf_pkg::KIND_FIND,  4,    1023, 1, 4,    0, 0);  // find ignores the second index
      add_op(dsuf_pkg::KIND_UNITE, 4,    4,    1, 4,    0, 0);
      add_cfg(2047);                                            // saturates to the store size
      add_op(dsuf_pkg::KIND_FIND,  1023, 0,    1, 1023, 0, 0);
      add_op(dsuf_pkg::KIND_UNITE, 1022, 1023, 1, 1023, 1, 0);
      add_cfg(0);
      add_op(dsuf_pkg::KIND_FIND,  0,    0,    1, 0,    0, 1);
      add_op(dsuf_pkg::KIND_SAME,  0,    0,    1, 0,    0, 1);
      add_cfg(1);
      add_op(dsuf_pkg::KIND_FIND,  0,    0,    1, 0,    0, 0);
      add_op(dsuf_pkg::KIND_UNITE, 0,    0,    1, 0,    0, 0);
      add_op(dsuf_pkg::KIND_SAME,  0,    1,    1, 0,    0, 1);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         row = script[i];
         if (row.is_cfg) begin
            write_count(row.cfg_value);
         end else begin
            send_item(row.kind, row.first, row.second, predicted);
            awaited_outcomes.push_back(row.typed ? row.want : predicted);
         end
      end

      plan = '{1024, 8, 64, 1, 1023, 2, 200, 0, 1024};
      plan[7] = $urandom_range(3, 1023);
      for (int ph = 0; ph < 9; ph++) begin
         write_count(plan[ph][dsuf_pkg::COUNT_W-1:0]);
         calm = (ph == 4 || ph == 7);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // let the engine drain completely once in a while
            if (n == 70 && (ph % 3) == 1) begin
               req_if.valid <= 1'b0;
               while (awaited_outcomes.size() != 0)
                  @(posedge clock);
            end
            r = $urandom_range(0, 99);
            if (r < 35)
               k = dsuf_pkg::KIND_UNITE;
            else if (r < 65)
               k = dsuf_pkg::KIND_FIND;
            else if (r < 93)
               k = dsuf_pkg::KIND_SAME;
            else
               k = KIND_SPARE;
            ia = pick_index();
            if (k == dsuf_pkg::KIND_FIND) begin
               raw = $urandom_range(0, STORE_DEPTH - 1);
               ib = raw[dsuf_pkg::INDEX_W-1:0];
            end else begin
               ib = pick_index();
            end
            send_item(k, ia, ib, predicted);
            awaited_outcomes.push_back(predicted);
         end
      end
      calm = 1'b0;
      req_if.valid <= 1'b0;

      while (awaited_outcomes.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && awaited_outcomes.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin : watchdog
      #5000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
